FILE: src/tpdo_ts_pkg.sv
// Shared types and constants for the transmit trigger scheduler.
// Used by tpdo_ts_chan, the top level and the port checker.
package tpdo_ts_pkg;

  localparam int CHANNELS            = 4;
  localparam int SETTINGS_W          = 48;
  localparam int CFG_IDX_W           = 2;
  localparam int TIME_W              = 64;
  localparam int COUNT_W             = 8;

  // Channel settings word layout.
  localparam int EN_BIT              = 0;
  localparam int TYPE_LSB            = 1;
  localparam int TYPE_W              = 8;
  localparam int INHIBIT_LSB         = 9;
  localparam int INHIBIT_W           = 16;
  localparam int TIMER_LSB           = 25;
  localparam int TIMER_W             = 16;
  localparam int PAYLOAD_LSB         = 41;
  localparam int PAYLOAD_W           = 7;

  localparam logic [SETTINGS_W-1:0] SETTINGS_RESET = 48'd1;

  // Scaled times: 16-bit field times 100 fits in 23 bits, times 1000 in 26 bits.
  localparam int INHIBIT_SPAN_W      = 23;
  localparam int PERIOD_SPAN_W       = 26;
  localparam int INHIBIT_UNIT_US     = 100;
  localparam int TIMER_UNIT_US       = 1000;

  localparam logic [TYPE_W-1:0] TYPE_SYNC_MIN  = 8'd1;
  localparam logic [TYPE_W-1:0] TYPE_SYNC_MAX  = 8'd240;
  localparam logic [TYPE_W-1:0] TYPE_EVENT_MFR = 8'd254;
  localparam logic [TYPE_W-1:0] TYPE_EVENT_DEV = 8'd255;

  localparam logic [PAYLOAD_W-1:0] CLASSIC_MAX_PAYLOAD = 7'd8;
  localparam logic [PAYLOAD_W-1:0] FD_MAX_PAYLOAD      = 7'd64;

  // Event codes.
  localparam logic [1:0] FUNC_SYNC       = 2'd0;
  localparam logic [1:0] FUNC_TICK       = 2'd1;
  localparam logic [1:0] FUNC_RESET_COMM = 2'd2;

  typedef struct packed {
    logic [1:0]          func;
    logic [TIME_W-1:0]   now_time_us;
    logic                operational;
    logic [CHANNELS-1:0] send_ready_mask;
  } in_item_t;

  typedef struct packed {
    logic [CHANNELS-1:0] transmit_mask;
    logic [CHANNELS-1:0] fd_mask;
  } out_item_t;

  // One event as seen by a single channel.
  typedef struct packed {
    logic              go;
    logic [1:0]        func;
    logic [TIME_W-1:0] now;
    logic              oper;
    logic              ready;
  } chan_evt_t;

  typedef struct packed {
    logic tx;
    logic fd;
  } chan_res_t;

endpackage

FILE: src/tpdo_ts_chan.sv
// One transmit channel: settings register, sync counter and last send time.
// Decides firing and send suppression for each event. Uses tpdo_ts_pkg.
module tpdo_ts_chan (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr,
  input  logic [tpdo_ts_pkg::SETTINGS_W-1:0]    cfg_wdata,
  input  tpdo_ts_pkg::chan_evt_t                evt,
  output tpdo_ts_pkg::chan_res_t                res
);

  logic [tpdo_ts_pkg::SETTINGS_W-1:0]     settings_r, settings_nxt;
  logic [tpdo_ts_pkg::COUNT_W-1:0]        count_r, count_nxt;
  logic [tpdo_ts_pkg::TIME_W-1:0]         last_r, last_nxt;

  logic                                   en;
  logic [tpdo_ts_pkg::TYPE_W-1:0]         ttype;
  logic [tpdo_ts_pkg::INHIBIT_W-1:0]      inhibit;
  logic [tpdo_ts_pkg::TIMER_W-1:0]        timer;
  logic [tpdo_ts_pkg::PAYLOAD_W-1:0]      payload;
  logic [tpdo_ts_pkg::INHIBIT_SPAN_W-1:0] inhibit_span;
  logic [tpdo_ts_pkg::PERIOD_SPAN_W-1:0]  period_span;
  logic [tpdo_ts_pkg::TIME_W-1:0]         elapsed;
  logic [tpdo_ts_pkg::COUNT_W-1:0]        count_inc;
  logic                                   never_sent;
  logic                                   inhibited;
  logic                                   period_done;
  logic                                   is_sync_type;
  logic                                   is_event_type;
  logic                                   do_sync;
  logic                                   do_tick;
  logic                                   do_reset;
  logic                                   fire;
  logic                                   send_ok;
  logic                                   tx;

  assign en      = settings_r[tpdo_ts_pkg::EN_BIT];
  assign ttype   = settings_r[tpdo_ts_pkg::TYPE_LSB +: tpdo_ts_pkg::TYPE_W];
  assign inhibit = settings_r[tpdo_ts_pkg::INHIBIT_LSB +: tpdo_ts_pkg::INHIBIT_W];
  assign timer   = settings_r[tpdo_ts_pkg::TIMER_LSB +: tpdo_ts_pkg::TIMER_W];
  assign payload = settings_r[tpdo_ts_pkg::PAYLOAD_LSB +: tpdo_ts_pkg::PAYLOAD_W];

  assign inhibit_span = tpdo_ts_pkg::INHIBIT_SPAN_W'(inhibit)
                      * tpdo_ts_pkg::INHIBIT_SPAN_W'(tpdo_ts_pkg::INHIBIT_UNIT_US);
  assign period_span  = tpdo_ts_pkg::PERIOD_SPAN_W'(timer)
                      * tpdo_ts_pkg::PERIOD_SPAN_W'(tpdo_ts_pkg::TIMER_UNIT_US);

  // Time since the last send, modulo 2^64 like the counter it models.
  assign elapsed    = evt.now - last_r;
  assign never_sent = (last_r == '0);

  assign inhibited =
    (elapsed[tpdo_ts_pkg::TIME_W-1:tpdo_ts_pkg::INHIBIT_SPAN_W] == '0) &&
    (elapsed[tpdo_ts_pkg::INHIBIT_SPAN_W-1:0] < inhibit_span);
  assign period_done =
    !((elapsed[tpdo_ts_pkg::TIME_W-1:tpdo_ts_pkg::PERIOD_SPAN_W] == '0) &&
      (elapsed[tpdo_ts_pkg::PERIOD_SPAN_W-1:0] < period_span));

  assign is_sync_type  = (ttype >= tpdo_ts_pkg::TYPE_SYNC_MIN) &&
                         (ttype <= tpdo_ts_pkg::TYPE_SYNC_MAX);
  assign is_event_type = (ttype == tpdo_ts_pkg::TYPE_EVENT_MFR) ||
                         (ttype == tpdo_ts_pkg::TYPE_EVENT_DEV);

  assign do_reset = evt.go && (evt.func == tpdo_ts_pkg::FUNC_RESET_COMM);
  assign do_sync  = evt.go && evt.oper && (evt.func == tpdo_ts_pkg::FUNC_SYNC) && is_sync_type;
  assign do_tick  = evt.go && evt.oper && (evt.func == tpdo_ts_pkg::FUNC_TICK) && is_event_type;

  assign count_inc = count_r + tpdo_ts_pkg::COUNT_W'(1);

  // The sync count restarts on reaching the type even if the send is suppressed.
  assign fire = (do_sync && (count_inc >= ttype)) ||
                (do_tick && (timer != '0) && (never_sent || period_done));

  assign send_ok = en && (payload != '0) && (payload <= tpdo_ts_pkg::FD_MAX_PAYLOAD) &&
                   (never_sent || !inhibited) && evt.ready;

  assign tx     = fire && send_ok;
  assign res.tx = tx;
  assign res.fd = tx && (payload > tpdo_ts_pkg::CLASSIC_MAX_PAYLOAD);

  always_comb begin
    settings_nxt = settings_r;
    count_nxt    = count_r;
    last_nxt     = last_r;
    if (do_reset) begin
      settings_nxt = tpdo_ts_pkg::SETTINGS_RESET;
      count_nxt    = '0;
      last_nxt     = '0;
    end else begin
      if (cfg_wr) begin
        settings_nxt = cfg_wdata;
      end
      if (do_sync) begin
        count_nxt = (count_inc >= ttype) ? '0 : count_inc;
      end
      if (tx) begin
        last_nxt = evt.now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settings_r <= tpdo_ts_pkg::SETTINGS_RESET;
      count_r    <= '0;
      last_r     <= '0;
    end else begin
      settings_r <= settings_nxt;
      count_r    <= count_nxt;
      last_r     <= last_nxt;
    end
  end

endmodule

FILE: src/tpdo_transmit_trigger_scheduler_core.sv
// Top level of the transmit trigger scheduler: input register, four channel
// units and the result register. Depends on tpdo_ts_pkg and tpdo_ts_chan.
//
//   Port group   Direction  Handshake         Payload
//   in_*         input      in_valid/in_stall  tpdo_ts_pkg::in_item_t
//   out_*        output     out_valid/out_stall tpdo_ts_pkg::out_item_t
//   cfg_*        input      cfg_we             cfg_idx, cfg_wdata (48 bits)
//
// Events pass from the input register to the result register, one per cycle
// while the result is not stalled, as each register feeds the next.
// Channel decisions are made between those two registers in one pass.
// Reset (rst_n low, synchronous) empties both registers and restores settings.
// When the result is stalled a full input register holds and in_stall rises.
module tpdo_transmit_trigger_scheduler_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  tpdo_ts_pkg::in_item_t                 in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output tpdo_ts_pkg::out_item_t                out_data,
  input  logic                                  cfg_we,
  input  logic [tpdo_ts_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [tpdo_ts_pkg::SETTINGS_W-1:0]    cfg_wdata
);

  logic                                 in_vld_r, in_vld_nxt;
  tpdo_ts_pkg::in_item_t                in_item_r;
  logic                                 out_vld_r, out_vld_nxt;
  tpdo_ts_pkg::out_item_t               out_item_r;
  logic                                 advance;
  logic                                 in_take;
  tpdo_ts_pkg::out_item_t               result;
  tpdo_ts_pkg::chan_res_t               chan_res [tpdo_ts_pkg::CHANNELS];

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  genvar c;
  generate
    for (c = 0; c < tpdo_ts_pkg::CHANNELS; c++) begin : g_chan
      tpdo_ts_pkg::chan_evt_t evt;

      assign evt.go    = advance;
      assign evt.func  = in_item_r.func;
      assign evt.now   = in_item_r.now_time_us;
      assign evt.oper  = in_item_r.operational;
      assign evt.ready = in_item_r.send_ready_mask[c];

      tpdo_ts_chan u_chan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_we && (cfg_idx == tpdo_ts_pkg::CFG_IDX_W'(c))),
        .cfg_wdata (cfg_wdata),
        .evt       (evt),
        .res       (chan_res[c])
      );

      assign result.transmit_mask[c] = chan_res[c].tx;
      assign result.fd_mask[c]       = chan_res[c].fd;
    end
  endgenerate

  always_comb begin
    in_vld_nxt = in_take || (in_vld_r && !advance);
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

FILE: src/tpdo_ts_chk.sv
// Port checker for the transmit trigger scheduler, bound to the top level.
// Depends on tpdo_ts_pkg and sees only the top level's ports.
module tpdo_ts_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input tpdo_ts_pkg::out_item_t out_data
);

  // A held result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The FD flag is only ever set for a channel that transmitted.
  a_fd_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.fd_mask & ~out_data.transmit_mask) == '0))
    else $error("fd flag without transmit");

  // Input backpressure only comes from a stalled, occupied result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind tpdo_transmit_trigger_scheduler_core tpdo_ts_chk u_tpdo_ts_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/tpdo_ts_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the transmit trigger scheduler: tracks settings writes, predicts
// the transmit and FD masks of every accepted event and checks each result transfer.
// Depends on tpdo_ts_pkg for the payload types and the settings layout.
module tpdo_ts_checker
  import tpdo_ts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [SETTINGS_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked_count
);

  logic [SETTINGS_W-1:0] chan_cfg [CHANNELS];
  logic [COUNT_W-1:0]    sync_cnt [CHANNELS];
  logic [TIME_W-1:0]     sent_at  [CHANNELS];
  out_item_t             mask_q [$];
  int                    fails   = 0;
  int                    checked = 0;

  function automatic void clear_state();
    for (int c = 0; c < CHANNELS; c++) begin
      chan_cfg[c] = SETTINGS_RESET;
      sync_cnt[c] = '0;
      sent_at[c]  = '0;
    end
  endfunction

  // Applies one event to the channel state and returns the masks it produces.
  function automatic out_item_t schedule_event(input in_item_t ev);
    out_item_t             res;
    logic [SETTINGS_W-1:0] s;
    logic [TYPE_W-1:0]     typ;
    logic [TIMER_W-1:0]    tmr;
    logic [PAYLOAD_W-1:0]  pay;
    logic [TIME_W-1:0]     elapsed;
    logic [TIME_W-1:0]     period;
    logic [TIME_W-1:0]     hold_off;
    logic                  fire;
    logic                  ok;
    res = '0;
    if (ev.func == FUNC_RESET_COMM) begin
      clear_state();
    end else if ((ev.func == FUNC_SYNC || ev.func == FUNC_TICK) && ev.operational) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s       = chan_cfg[c];
        typ     = s[TYPE_LSB +: TYPE_W];
        tmr     = s[TIMER_LSB +: TIMER_W];
        pay     = s[PAYLOAD_LSB +: PAYLOAD_W];
        elapsed = ev.now_time_us - sent_at[c];
        fire    = 1'b0;
        if (ev.func == FUNC_SYNC) begin
          // The count advances and wraps even when the send ends up suppressed.
          if (typ >= TYPE_SYNC_MIN && typ <= TYPE_SYNC_MAX) begin
            sync_cnt[c] = sync_cnt[c] + 1'b1;
            if (sync_cnt[c] >= typ) begin
              sync_cnt[c] = '0;
              fire = 1'b1;
            end
          end
        end else if ((typ == TYPE_EVENT_MFR || typ == TYPE_EVENT_DEV) && tmr != '0) begin
          period = 64'(tmr) * 64'(TIMER_UNIT_US);
          if (sent_at[c] == '0 || elapsed >= period) fire = 1'b1;
        end
        if (fire) begin
          hold_off = 64'(s[INHIBIT_LSB +: INHIBIT_W]) * 64'(INHIBIT_UNIT_US);
          ok = s[EN_BIT] && pay != '0 && pay <= FD_MAX_PAYLOAD &&
               !(sent_at[c] != '0 && elapsed < hold_off) && ev.send_ready_mask[c];
          if (ok) begin
            sent_at[c] = ev.now_time_us;
            res.transmit_mask[c] = 1'b1;
            res.fd_mask[c] = pay > CLASSIC_MAX_PAYLOAD;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      clear_state();
      mask_q.delete();
    end else begin
      if (cfg_we && cfg_idx < CHANNELS) chan_cfg[cfg_idx] = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (mask_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected result: tx %b fd %b", $realtime,
                     out_data.transmit_mask, out_data.fd_mask);
        end else begin
          want = mask_q.pop_front();
          checked++;
          if (out_data.transmit_mask !== want.transmit_mask ||
              out_data.fd_mask !== want.fd_mask) begin
            fails++;
            if (fails <= 10)
              $display("[%0t] result %0d mismatch: expected tx %b fd %b, got tx %b fd %b",
                       $realtime, checked, want.transmit_mask, want.fd_mask,
                       out_data.transmit_mask, out_data.fd_mask);
          end
        end
      end
      if (in_valid && !in_stall) mask_q.push_back(schedule_event(in_data));
    end
    fail_count    <= fails;
    pending       <= mask_q.size();
    checked_count <= checked;
  end

endmodule

FILE: tb/tpdo_transmit_trigger_scheduler_core_test.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the transmit trigger scheduler core: directed events,
// then random phases under several channel settings. Depends on tpdo_ts_pkg,
// the core and tpdo_ts_checker, which does the result checking.
module tpdo_transmit_trigger_scheduler_core_test;
  import tpdo_ts_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         PHASES      = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [SETTINGS_W-1:0] cfg_wdata;

  int                    fail_count;
  int                    pending;
  int                    checked_count;

  bit                    idle_on   = 1'b1;
  int                    stall_left = 0;
  int                    n_events  = 0;
  int                    n_phases  = 0;
  logic [TIME_W-1:0]     cur_time  = '0;
  logic [SETTINGS_W-1:0] phase_cfg [CHANNELS];

  tpdo_transmit_trigger_scheduler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  tpdo_ts_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("** tpdo_transmit_trigger_scheduler_core: FAILED **");
    $finish;
  end

  // Result side back-pressure in random bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!idle_on) stall_left = 0;
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
      end
    end
  end

  function automatic logic [SETTINGS_W-1:0] pack_settings(logic en, logic [TYPE_W-1:0] typ,
      logic [INHIBIT_W-1:0] inh, logic [TIMER_W-1:0] tmr, logic [PAYLOAD_W-1:0] pay);
    return {pay, tmr, inh, typ, en};
  endfunction

  // Mostly short sync counts and millisecond timers so that channels fire often.
  function automatic logic [SETTINGS_W-1:0] rand_settings();
    logic [TYPE_W-1:0]    typ;
    logic [INHIBIT_W-1:0] inh;
    logic [TIMER_W-1:0]   tmr;
    logic [PAYLOAD_W-1:0] pay;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: typ = TYPE_W'($urandom_range(1, 4));
      4:          typ = TYPE_W'($urandom_range(1, 240));
      5, 6, 7:    typ = $urandom_range(0, 1) ? TYPE_EVENT_DEV : TYPE_EVENT_MFR;
      8:          typ = '0;
      default:    typ = TYPE_W'($urandom_range(241, 253));
    endcase
    inh = ($urandom_range(0, 7) == 0) ? INHIBIT_W'($urandom) : INHIBIT_W'($urandom_range(0, 20));
    case ($urandom_range(0, 9))
      0:       tmr = '0;
      1:       tmr = TIMER_W'($urandom);
      default: tmr = TIMER_W'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 19))
      0:       pay = '0;
      1:       pay = PAYLOAD_W'($urandom_range(65, 127));
      default: pay = PAYLOAD_W'($urandom_range(1, 64));
    endcase
    return pack_settings($urandom_range(0, 9) != 0, typ, inh, tmr, pay);
  endfunction

  function automatic in_item_t next_event();
    in_item_t it;
    int       pick;
    case ($urandom_range(0, 39))
      0:       cur_time = {$urandom, $urandom};
      1:       cur_time = '0;
      2:       cur_time = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3000);
      default: cur_time = cur_time + $urandom_range(0, 1500);
    endcase
    pick = $urandom_range(0, 799);
    if (pick == 0)        it.func = FUNC_RESET_COMM;
    else if (pick < 16)   it.func = FUNC_UNUSED;
    else if (pick[0])     it.func = FUNC_SYNC;
    else                  it.func = FUNC_TICK;
    it.now_time_us     = cur_time;
    it.operational     = $urandom_range(0, 9) != 0;
    it.send_ready_mask = ($urandom_range(0, 2) == 0) ? CHANNELS'($urandom) : '1;
    return it;
  endfunction

  // Holds the event until the transfer, then sometimes leaves a gap.
  task automatic push_event(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_events++;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic push_fields(logic [1:0] f, logic [TIME_W-1:0] t, logic op,
      logic [CHANNELS-1:0] rdy);
    in_item_t it;
    it.func            = f;
    it.now_time_us     = t;
    it.operational     = op;
    it.send_ready_mask = rdy;
    push_event(it);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_settings();
    for (int i = 0; i < CHANNELS; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= phase_cfg[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    n_phases++;
  endtask

  initial begin
    int count;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every sync, two-sync count with inhibit, millisecond timer, and an
    // invalid oversized payload on the slow timer channel.
    phase_cfg[0] = pack_settings(1'b1, 8'd1, 16'd0, 16'd0, 7'd8);
    phase_cfg[1] = pack_settings(1'b1, 8'd2, 16'd10, 16'd0, 7'd9);
    phase_cfg[2] = pack_settings(1'b1, TYPE_EVENT_MFR, 16'd5, 16'd1, 7'd64);
    phase_cfg[3] = pack_settings(1'b1, TYPE_EVENT_DEV, 16'hFFFF, 16'hFFFF, 7'd65);
    write_settings();
    push_fields(FUNC_SYNC, 64'd100, 1'b0, 4'hF);   // not operational, no counting
    push_fields(FUNC_SYNC, 64'd200, 1'b1, 4'hF);
    push_fields(FUNC_SYNC, 64'd300, 1'b1, 4'hF);
    push_fields(FUNC_SYNC, 64'd400, 1'b1, 4'h0);   // nothing ready
    push_fields(FUNC_SYNC, 64'd500, 1'b1, 4'hF);   // count wraps while inhibited
    push_fields(FUNC_TICK, 64'd0, 1'b1, 4'hF);     // a send at time zero looks unsent
    push_fields(FUNC_TICK, 64'd10, 1'b1, 4'hF);
    push_fields(FUNC_TICK, 64'd500, 1'b1, 4'hF);
    push_fields(FUNC_TICK, 64'd1010, 1'b1, 4'hF);
    push_fields(FUNC_TICK, 64'd1500, 1'b0, 4'hF);
    push_fields(FUNC_UNUSED, 64'd2500, 1'b1, 4'hF);
    push_fields(FUNC_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'hF);
    push_fields(FUNC_TICK, 64'd500, 1'b1, 4'hF);   // elapsed time wraps around
    push_fields(FUNC_SYNC, 64'd3000, 1'b1, 4'b0101);
    push_fields(FUNC_SYNC, 64'd3100, 1'b1, 4'b1010);
    push_fields(FUNC_RESET_COMM, 64'd3200, 1'b0, 4'hF);
    push_fields(FUNC_SYNC, 64'd3300, 1'b1, 4'hF);
    push_fields(FUNC_TICK, 64'd9000, 1'b1, 4'hF);
    wait_results();

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p % 3 != 2) && (p != PHASES - 1);
      if (p == 1) begin
        phase_cfg[0] = '1;
        phase_cfg[1] = '0;
        phase_cfg[2] = {16'($urandom), 32'($urandom)};
        phase_cfg[3] = {16'($urandom), 32'($urandom)};
        count = 100;
      end else begin
        for (int c = 0; c < CHANNELS; c++) phase_cfg[c] = rand_settings();
        count = 250;
      end
      write_settings();
      for (int k = 0; k < count; k++) begin
        push_event(next_event());
        if ($urandom_range(0, 299) == 0) wait_results();
      end
      wait_results();
    end

    repeat (5) @(negedge clk);
    $display("%0d events over %0d settings phases, %0d results compared", n_events,
             n_phases, checked_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** tpdo_transmit_trigger_scheduler_core: PASSED **");
    end else begin
      $display("%0d failures", fail_count);
      $display("** tpdo_transmit_trigger_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule
